>>> src/zbd_pkg.sv
// Shared types, constants and opcode classification functions for the Z80 boundary decoder.
package zbd_pkg;

   localparam int BufDepth   = 12;
   localparam int MaxResults = 12;

   localparam logic [7:0] PFX_IX  = 8'hDD;
   localparam logic [7:0] PFX_IY  = 8'hFD;
   localparam logic [7:0] OP_ED   = 8'hED;
   localparam logic [7:0] OP_CB   = 8'hCB;
   localparam logic [7:0] ED_MAIN = 8'h40;
   localparam logic [7:0] ED_BLK  = 8'hA0;

   localparam logic [1:0] KIND_HL = 2'd0;
   localparam logic [1:0] KIND_IX = 2'd1;
   localparam logic [1:0] KIND_IY = 2'd2;

   localparam logic [1:0] TBL_MAIN = 2'd0;
   localparam logic [1:0] TBL_CB   = 2'd1;
   localparam logic [1:0] TBL_ED   = 2'd2;

   localparam logic [2:0] OPK_NONE   = 3'd0;
   localparam logic [2:0] OPK_IMM16  = 3'd1;
   localparam logic [2:0] OPK_ADDR16 = 3'd2;
   localparam logic [2:0] OPK_SIMM8  = 3'd3;
   localparam logic [2:0] OPK_UIMM8  = 3'd4;
   localparam logic [2:0] OPK_REL    = 3'd5;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_UNDEF = 2'd1;
   localparam logic [1:0] STS_TRUNC = 2'd2;
   localparam logic [1:0] STS_OVF   = 2'd3;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [15:0]       insn_address;
      logic [3:0]        insn_length;
      logic [1:0]        index_kind;
      logic [1:0]        opcode_table;
      logic [7:0]        opcode_value;
      logic              has_displacement;
      logic signed [7:0] displacement;
      logic [2:0]        operand_kind;
      logic [15:0]       operand_value;
      logic [1:0]        status;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic       wr;
      logic [7:0] wr_byte;
      logic       drop;
      logic [3:0] drop_len;
      logic       clear;
   } buf_ctl_type;

   typedef struct packed {
      logic [3:0] count;
      logic [7:0] rd_byte;
   } buf_sts_type;

   function automatic logic [3:0] wrap_idx(input logic [4:0] s);
      logic [4:0] t;
      t = (s >= 5'(BufDepth)) ? s - 5'(BufDepth) : s;
      return t[3:0];
   endfunction

   function automatic logic is_prefix(input logic [7:0] b);
      return (b == PFX_IX) || (b == PFX_IY);
   endfunction

   function automatic logic uses_hl_mem(input logic [7:0] op);
      logic r;
      r = 1'b0;
      if (op inside {8'h34, 8'h35, 8'h36}) begin
         r = 1'b1;
      end else if (op >= ED_MAIN && op < 8'hC0 && op != 8'h76 &&
                   (op[2:0] == 3'd6 || op[7:3] == 5'b01110)) begin
         r = 1'b1;
      end
      return r;
   endfunction

   function automatic logic [2:0] main_operand(input logic [7:0] op);
      logic [2:0] k;
      k = OPK_NONE;
      if (op inside {8'h01, 8'h11, 8'h21}) begin
         k = OPK_IMM16;
      end else if (op inside {8'h22, 8'h2A, 8'h31, 8'h32, 8'h3A, 8'hC3, 8'hCD}) begin
         k = OPK_ADDR16;
      end else if (op >= 8'hC0 && (op[2:0] == 3'd2 || op[2:0] == 3'd4)) begin
         k = OPK_ADDR16;
      end else if (op inside {8'hD3, 8'hDB, 8'hE6, 8'hEE, 8'hF6}) begin
         k = OPK_UIMM8;
      end else if ((op < 8'h40 || op >= 8'hC0) && op[2:0] == 3'd6) begin
         k = OPK_SIMM8;
      end else if (op == 8'h10 || op == 8'h18 || (op < 8'h40 && (op & 8'hE7) == 8'h20)) begin
         k = OPK_REL;
      end
      return k;
   endfunction

   function automatic logic [1:0] operand_bytes(input logic [2:0] k);
      logic [1:0] r;
      if (k == OPK_IMM16 || k == OPK_ADDR16) begin
         r = 2'd2;
      end else if (k != OPK_NONE) begin
         r = 2'd1;
      end else begin
         r = 2'd0;
      end
      return r;
   endfunction

   function automatic logic ed_defined(input logic [7:0] op);
      logic r;
      r = 1'b0;
      if (op >= ED_MAIN && op < 8'h80) begin
         r = (op != 8'h77) && (op != 8'h7F);
      end else if (op >= ED_BLK && op < 8'hC0) begin
         r = ~op[2];
      end
      return r;
   endfunction

endpackage

>>> src/zbd_buf.sv
// Circular pending-byte buffer with one write port and one offset read port.
module zbd_buf import zbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  buf_ctl_type ctl,
   input  logic [3:0]  rd_ptr,
   output buf_sts_type sts
);

   logic [7:0] mem_ff [BufDepth];
   logic [3:0] head_ff, head_in;
   logic [3:0] count_ff, count_in;
   logic [3:0] base_cnt;
   logic [3:0] wr_idx;

   assign base_cnt = (count_ff >= 4'(BufDepth)) ? 4'(BufDepth - 1) : count_ff;
   assign wr_idx   = wrap_idx({1'b0, head_ff} + {1'b0, base_cnt});

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         head_in  = 4'd0;
         count_in = 4'd0;
      end else if (ctl.wr) begin
         count_in = base_cnt + 4'd1;
      end else if (ctl.drop) begin
         head_in  = wrap_idx({1'b0, head_ff} + {1'b0, ctl.drop_len});
         count_in = count_ff - ctl.drop_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 4'd0;
         count_ff <= 4'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem_ff[wr_idx] <= ctl.wr_byte;
      end
   end

   assign sts.count   = count_ff;
   assign sts.rd_byte = mem_ff[wrap_idx({1'b0, head_ff} + {1'b0, rd_ptr})];

endmodule

>>> src/zbd_seq.sv
// Byte-walking sequencer that decodes one instruction per pass over the buffer.
module zbd_seq import zbd_pkg::*; #(
   parameter int RUN_BOUND = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        idle,
   input  logic [15:0] next_addr,
   input  buf_sts_type sts,
   output buf_ctl_type ctl,
   output logic [3:0]  rd_ptr
);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_SCAN = 9'b000000010,
      S_ED2  = 9'b000000100,
      S_CBD  = 9'b000001000,
      S_CBOP = 9'b000010000,
      S_DISP = 9'b000100000,
      S_OPLO = 9'b001000000,
      S_OPHI = 9'b010000000,
      S_SEND = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] ptr_ff, ptr_in;
   logic [1:0] kind_ff, kind_in;
   logic [1:0] table_ff, table_in;
   logic [7:0] op_ff, op_in;
   logic [7:0] b0_ff, b0_in;
   logic [7:0] d_ff, d_in;
   logic       hasd_ff, hasd_in;
   logic [7:0] lo_ff, lo_in;
   logic [2:0] okind_ff, okind_in;
   logic       fin_ff, fin_in;
   logic       ovf_ff, ovf_in;
   logic [3:0] cnt_ff, cnt_in;
   rsp_type    hold_ff, hold_in;
   logic       hold_v_ff, hold_v_in;
   logic       last_ff, last_in;

   rsp_type    res;
   logic       dec_go, finish, short_data, accept;
   logic [7:0] rd;
   logic [3:0] n;
   logic [4:0] n5, ptr1, ptr2;
   logic [2:0] k;
   logic [15:0] rel_off;

   assign rd      = sts.rd_byte;
   assign n       = sts.count;
   assign n5      = {1'b0, n};
   assign ptr1    = {1'b0, ptr_ff} + 5'd1;
   assign ptr2    = {1'b0, ptr_ff} + 5'd2;
   assign k       = main_operand(rd);
   assign rel_off = {{8{rd[7]}}, rd};
   assign rd_ptr  = ptr_ff;

   assign idle      = (state_ff == S_IDLE);
   assign req_ready = idle && !csr_valid;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_SEND);

   always_comb begin
      rsp_data             = hold_ff;
      rsp_data.last_result = last_ff;
   end

   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      kind_in    = kind_ff;
      table_in   = table_ff;
      op_in      = op_ff;
      b0_in      = b0_ff;
      d_in       = d_ff;
      hasd_in    = hasd_ff;
      lo_in      = lo_ff;
      okind_in   = okind_ff;
      fin_in     = fin_ff;
      ovf_in     = ovf_ff;
      cnt_in     = cnt_ff;
      hold_in    = hold_ff;
      hold_v_in  = hold_v_ff;
      last_in    = last_ff;
      dec_go     = 1'b0;
      finish     = 1'b0;
      short_data = 1'b0;
      res              = '0;
      res.insn_address = next_addr;
      ctl              = '0;
      ctl.wr           = accept;
      ctl.wr_byte      = req_data.code_byte;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
               ptr_in   = 4'd0;
               kind_in  = KIND_HL;
               fin_in   = req_data.end_of_data;
               ovf_in   = 1'b1;
               cnt_in   = 4'd0;
            end
         end
         S_SCAN: begin
            if (ptr_ff == 4'd0) begin
               b0_in = rd;
            end
            if (ptr_ff == 4'd0 && (n == 4'd0 || cnt_ff == 4'(MaxResults))) begin
               finish = 1'b1;
            end else if (ptr_ff >= n) begin
               if (ovf_ff && int'(n) > RUN_BOUND) begin
                  dec_go           = 1'b1;
                  res.insn_length  = 4'd1;
                  res.opcode_value = b0_ff;
                  res.status       = STS_OVF;
               end else begin
                  ovf_in     = 1'b0;
                  short_data = 1'b1;
               end
            end else if (is_prefix(rd)) begin
               kind_in = (rd == PFX_IX) ? KIND_IX : KIND_IY;
               ptr_in  = ptr1[3:0];
            end else begin
               ovf_in  = 1'b0;
               op_in   = rd;
               hasd_in = 1'b0;
               d_in    = 8'd0;
               if (rd == OP_ED) begin
                  if (ptr1 >= n5) begin
                     short_data = 1'b1;
                  end else begin
                     ptr_in   = ptr1[3:0];
                     state_in = S_ED2;
                  end
               end else if (rd == OP_CB) begin
                  if (ptr_ff != 4'd0) begin
                     if (ptr2 >= n5) begin
                        if (fin_ff) begin
                           dec_go           = 1'b1;
                           res.index_kind   = kind_ff;
                           res.opcode_table = TBL_CB;
                           res.opcode_value = OP_CB;
                           res.insn_length  = 4'd2;
                           res.status       = STS_TRUNC;
                        end else begin
                           finish = 1'b1;
                        end
                     end else begin
                        ptr_in   = ptr1[3:0];
                        state_in = S_CBD;
                     end
                  end else if (n < 4'd2) begin
                     short_data = 1'b1;
                  end else begin
                     ptr_in   = 4'd1;
                     state_in = S_CBOP;
                  end
               end else begin
                  okind_in = k;
                  table_in = TBL_MAIN;
                  if (kind_ff != KIND_HL && uses_hl_mem(rd)) begin
                     if (ptr1 >= n5) begin
                        short_data = 1'b1;
                     end else begin
                        ptr_in   = ptr1[3:0];
                        state_in = S_DISP;
                     end
                  end else if (ptr1 + 5'(operand_bytes(k)) > n5) begin
                     short_data = 1'b1;
                  end else if (operand_bytes(k) == 2'd0) begin
                     dec_go           = 1'b1;
                     res.index_kind   = kind_ff;
                     res.opcode_value = rd;
                     res.insn_length  = ptr1[3:0];
                  end else begin
                     ptr_in   = ptr1[3:0];
                     state_in = S_OPLO;
                  end
               end
            end
         end
         S_ED2: begin
            if (!ed_defined(rd)) begin
               dec_go           = 1'b1;
               res.index_kind   = kind_ff;
               res.opcode_table = TBL_ED;
               res.opcode_value = rd;
               res.insn_length  = ptr1[3:0];
               res.status       = STS_UNDEF;
            end else if (rd < 8'h80 && rd[2:0] == 3'd3) begin
               if (ptr2 >= n5) begin
                  if (fin_ff) begin
                     dec_go           = 1'b1;
                     res.index_kind   = kind_ff;
                     res.opcode_table = TBL_ED;
                     res.opcode_value = rd;
                     res.insn_length  = ptr1[3:0];
                     res.status       = STS_TRUNC;
                  end else begin
                     finish = 1'b1;
                  end
               end else begin
                  op_in    = rd;
                  okind_in = OPK_ADDR16;
                  table_in = TBL_ED;
                  ptr_in   = ptr1[3:0];
                  state_in = S_OPLO;
               end
            end else begin
               dec_go           = 1'b1;
               res.index_kind   = kind_ff;
               res.opcode_table = TBL_ED;
               res.opcode_value = rd;
               res.insn_length  = ptr1[3:0];
            end
         end
         S_CBD: begin
            d_in     = rd;
            hasd_in  = 1'b1;
            ptr_in   = ptr1[3:0];
            state_in = S_CBOP;
         end
         S_CBOP: begin
            dec_go               = 1'b1;
            res.index_kind       = kind_ff;
            res.opcode_table     = TBL_CB;
            res.opcode_value     = rd;
            res.insn_length      = ptr1[3:0];
            res.has_displacement = hasd_ff;
            res.displacement     = d_ff;
         end
         S_DISP: begin
            d_in    = rd;
            hasd_in = 1'b1;
            if (ptr1 + 5'(operand_bytes(okind_ff)) > n5) begin
               short_data = 1'b1;
            end else if (operand_bytes(okind_ff) == 2'd0) begin
               dec_go               = 1'b1;
               res.index_kind       = kind_ff;
               res.opcode_value     = op_ff;
               res.has_displacement = 1'b1;
               res.displacement     = rd;
               res.insn_length      = ptr1[3:0];
            end else begin
               ptr_in   = ptr1[3:0];
               state_in = S_OPLO;
            end
         end
         S_OPLO: begin
            lo_in = rd;
            if (operand_bytes(okind_ff) == 2'd2) begin
               ptr_in   = ptr1[3:0];
               state_in = S_OPHI;
            end else begin
               dec_go               = 1'b1;
               res.index_kind       = kind_ff;
               res.opcode_table     = table_ff;
               res.opcode_value     = op_ff;
               res.has_displacement = hasd_ff;
               res.displacement     = d_ff;
               res.operand_kind     = okind_ff;
               res.insn_length      = ptr1[3:0];
               if (okind_ff == OPK_UIMM8) begin
                  res.operand_value = {8'd0, rd};
               end else if (okind_ff == OPK_SIMM8) begin
                  res.operand_value = rel_off;
               end else begin
                  res.operand_value = next_addr + {12'd0, ptr1[3:0]} + rel_off;
               end
            end
         end
         S_OPHI: begin
            dec_go               = 1'b1;
            res.index_kind       = kind_ff;
            res.opcode_table     = table_ff;
            res.opcode_value     = op_ff;
            res.has_displacement = hasd_ff;
            res.displacement     = d_ff;
            res.operand_kind     = okind_ff;
            res.operand_value    = {rd, lo_ff};
            res.insn_length      = ptr1[3:0];
         end
         S_SEND: begin
            if (rsp_ready) begin
               hold_v_in = 1'b0;
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_SCAN;
                  ptr_in   = 4'd0;
                  kind_in  = KIND_HL;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (short_data) begin
         if (fin_ff) begin
            dec_go           = 1'b1;
            res              = '0;
            res.insn_address = next_addr;
            res.insn_length  = 4'd1;
            res.opcode_value = (state_ff == S_SCAN && ptr_ff == 4'd0) ? rd : b0_ff;
            res.status       = STS_UNDEF;
         end else begin
            finish = 1'b1;
         end
      end

      if (dec_go) begin
         if (hold_v_ff) begin
            state_in = S_SEND;
            last_in  = 1'b0;
         end else begin
            hold_in      = res;
            hold_v_in    = 1'b1;
            ctl.drop     = 1'b1;
            ctl.drop_len = res.insn_length;
            cnt_in       = cnt_ff + 4'd1;
            state_in     = S_SCAN;
            ptr_in       = 4'd0;
            kind_in      = KIND_HL;
         end
      end

      if (finish) begin
         ctl.clear = fin_ff;
         if (hold_v_ff) begin
            state_in = S_SEND;
            last_in  = 1'b1;
         end else begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         hold_v_ff <= 1'b0;
         last_ff   <= 1'b0;
         cnt_ff    <= 4'd0;
         ovf_ff    <= 1'b0;
         fin_ff    <= 1'b0;
         ptr_ff    <= 4'd0;
         kind_ff   <= KIND_HL;
      end else begin
         state_ff  <= state_in;
         hold_v_ff <= hold_v_in;
         last_ff   <= last_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
         fin_ff    <= fin_in;
         ptr_ff    <= ptr_in;
         kind_ff   <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      table_ff <= table_in;
      op_ff    <= op_in;
      b0_ff    <= b0_in;
      d_ff     <= d_in;
      hasd_ff  <= hasd_in;
      lo_ff    <= lo_in;
      okind_ff <= okind_in;
      hold_ff  <= hold_in;
   end

endmodule

>>> src/z80_instruction_boundary_decoder.sv
// Top level of the Z80 instruction boundary decoder.
//
//   channel  direction  handshake            contents
//   req      in         req_valid/req_ready  one code byte and the end-of-data flag
//   rsp      out        rsp_valid/rsp_ready  one decoded instruction or data result
//   csr      in         csr_valid/csr_ready  origin address of the stream
//
// The sequencer walks the buffered bytes one per cycle through a single read port.
// One decode pass inspects buffered bytes from the head of the buffer onward.
// A request takes one pass per result and a closing pass that ends the walk,
// plus a repeated pass and one send for every result after the first, and one
// final send when the request made any result.
// A stalled rsp_ready holds the block; no request is taken until all results have left.
// Reset is synchronous and empties the buffer; the origin write also empties it.
module z80_instruction_boundary_decoder import zbd_pkg::*; #(
   parameter int PREFIX_RUN_MAX = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int RunBound = (PREFIX_RUN_MAX < 8) ? PREFIX_RUN_MAX : 8;

   logic [15:0] next_addr_ff, next_addr_in;
   buf_ctl_type seq_ctl, buf_ctl;
   buf_sts_type buf_sts;
   logic [3:0]  rd_ptr;
   logic        idle;
   logic        csr_fire;

   assign csr_ready = idle;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      buf_ctl       = seq_ctl;
      buf_ctl.clear = seq_ctl.clear || csr_fire;
   end

   always_comb begin
      next_addr_in = next_addr_ff;
      if (csr_fire) begin
         next_addr_in = csr_data;
      end else if (seq_ctl.drop) begin
         next_addr_in = next_addr_ff + {12'd0, seq_ctl.drop_len};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_addr_ff <= 16'd0;
      end else begin
         next_addr_ff <= next_addr_in;
      end
   end

   zbd_buf u_buf (
      .clock  (clock),
      .reset  (reset),
      .ctl    (buf_ctl),
      .rd_ptr (rd_ptr),
      .sts    (buf_sts)
   );

   zbd_seq #(
      .RUN_BOUND (RunBound)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .idle      (idle),
      .next_addr (next_addr_ff),
      .sts       (buf_sts),
      .ctl       (seq_ctl),
      .rd_ptr    (rd_ptr)
   );

endmodule

>>> src/zbd_checker.sv
// Port-level checker for the Z80 boundary decoder and its bind statement.
module zbd_checker import zbd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Result changed or dropped while stalled.");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("Request taken while a result is pending.");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.insn_length != 4'd0 && rsp_data.insn_length <= 4'd12)
      else $error("Instruction length out of range.");

   a_ovf_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STS_OVF |->
         rsp_data.insn_length == 4'd1 && rsp_data.operand_kind == OPK_NONE &&
         rsp_data.index_kind == KIND_HL)
      else $error("Malformed prefix overflow result.");

endmodule

bind z80_instruction_boundary_decoder zbd_checker u_zbd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
